// ===== rtl/core/biphase_line_codec_unit_macros.svh =====
// assertion macros shared by the biphase line codec checker
// no dependencies; expects clk and rst_n in the scope of use
`ifndef BIPHASE_LINE_CODEC_UNIT_MACROS_SVH
`define BIPHASE_LINE_CODEC_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define BLC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/blc_pkg.sv =====
// shared types and codes for the biphase line codec
// no dependencies
`default_nettype none

package blc_pkg;

    localparam int WORD_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 2;

    // line code selection
    localparam logic [1:0] MODE_MANCH = 2'd0;
    localparam logic [1:0] MODE_DIFF  = 2'd1;
    localparam logic [1:0] MODE_BMC   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECODE_DIR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_CHIPS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LEVEL  = 2'd3;

    // one accepted input item
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              restart;
    } blc_item_t;

    // one result item
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              code_error;
        logic              line_level;
    } blc_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/biphase_line_codec_unit.sv =====
// biphase line codec top level: Manchester, differential Manchester, biphase mark
// depends on blc_pkg
`default_nettype none

// Usage
// - input channel: in_valid/in_ready carry word_in and restart; encode takes data
//   in the low DATA_BITS bits, decode takes 2*DATA_BITS chips, first chip in bit 0
// - output channel: out_valid/out_ready carry word_out, code_error, line_level
// - config channel: cfg_valid/cfg_ready carry cfg_index and cfg_data; cfg_ready
//   is always high; write only while no item is in flight
// - path: an input item passes the input register, then the result register,
//   before its result is offered
// - throughput: one item per cycle while out_ready is high, set by the combinational
//   coding logic between the two registers; the stored line level is updated as each
//   item moves into the result register
// - stall: while out_ready is low the result holds; one more item waits in
//   the input register, then in_ready drops
// - reset: valid flags and configuration registers clear, channels empty, stored line level 0,
//   Manchester encode without inversion
module biphase_line_codec_unit
    import blc_pkg::*;
#(
    parameter int DATA_BITS = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // input item channel
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [WORD_W-1:0]     word_in,
    input  wire logic                  restart,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [WORD_W-1:0]          word_out,
    output logic                       code_error,
    output logic                       line_level
);

    localparam int CHIPS = 2 * DATA_BITS;
    localparam int WIDE  = (CHIPS > WORD_W) ? CHIPS : WORD_W;

    // configuration registers
    logic [1:0] code_mode_reg;
    logic       decode_dir_reg;
    logic       invert_chips_reg;
    logic       start_level_reg;

    // stored line level
    logic       last_level_reg;
    logic       last_level_next;

    // pipeline registers
    logic        s1_valid_reg;
    blc_item_t   s1_item_reg;
    logic        out_valid_reg;
    blc_result_t out_res_reg;
    blc_result_t out_res_next;

    // handshake control
    logic in_xfer;
    logic out_free;
    logic s1_adv;

    // coding datapath
    logic [1:0]       mode_eff;
    logic             inv_en;
    logic             lvl_start;
    logic [WIDE-1:0]  w_ext;
    logic [CHIPS-1:0] enc_chips;
    logic [CHIPS-1:0] dec_chips;
    logic [DATA_BITS-1:0] dec_data;
    logic             dec_err;
    logic [WIDE-1:0]  enc_ext;
    logic [WIDE-1:0]  dec_ext;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign s1_adv    = s1_valid_reg && out_free;
    assign in_ready  = !s1_valid_reg || out_free;
    assign in_xfer   = in_valid && in_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_mode_reg    <= MODE_MANCH;
            decode_dir_reg   <= 1'b0;
            invert_chips_reg <= 1'b0;
            start_level_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CODE_MODE:    code_mode_reg    <= cfg_data;
                CFG_DECODE_DIR:   decode_dir_reg   <= cfg_data[0];
                CFG_INVERT_CHIPS: invert_chips_reg <= cfg_data[0];
                CFG_START_LEVEL:  start_level_reg  <= cfg_data[0];
            endcase
        end
    end

    // effective mode: the unused code behaves as biphase mark
    always_comb
    begin
        if (code_mode_reg == MODE_MANCH)
            mode_eff = MODE_MANCH;
        else if (code_mode_reg == MODE_DIFF)
            mode_eff = MODE_DIFF;
        else
            mode_eff = MODE_BMC;
    end

    assign inv_en    = (mode_eff == MODE_MANCH) && invert_chips_reg;
    assign lvl_start = s1_item_reg.restart ? start_level_reg : last_level_reg;
    assign w_ext     = WIDE'(s1_item_reg.word);

    // encoder: one cell per data bit, level carried cell to cell in the differential modes
    always_comb
    begin
        logic lvl;
        logic d;
        logic a;
        logic b;
        lvl       = lvl_start;
        enc_chips = '0;
        for (int i = 0; i < DATA_BITS; i++)
        begin
            d = w_ext[i];
            unique case (mode_eff)
                MODE_MANCH:
                begin
                    a = d;
                    b = !d;
                end
                MODE_DIFF:
                begin
                    lvl = lvl ^ d;
                    a   = !lvl;
                    b   = lvl;
                end
                default:
                begin
                    a   = !lvl;
                    b   = lvl ^ !d;
                    lvl = b;
                end
            endcase
            enc_chips[2*i]   = a;
            enc_chips[2*i+1] = b;
        end
        enc_chips = enc_chips ^ {CHIPS{inv_en}};
    end

    // decoder: each cell checked against its pair or the previous chip
    assign dec_chips = w_ext[CHIPS-1:0] ^ {CHIPS{inv_en}};

    always_comb
    begin
        logic prev;
        logic a;
        logic b;
        prev     = lvl_start;
        dec_data = '0;
        dec_err  = 1'b0;
        for (int i = 0; i < DATA_BITS; i++)
        begin
            a = dec_chips[2*i];
            b = dec_chips[2*i+1];
            unique case (mode_eff)
                MODE_MANCH:
                begin
                    if (a == b)
                        dec_err = 1'b1;
                    dec_data[i] = a;
                end
                MODE_DIFF:
                begin
                    if (a == b)
                        dec_err = 1'b1;
                    dec_data[i] = (a == prev);
                end
                default:
                begin
                    if (a == prev)
                        dec_err = 1'b1;
                    dec_data[i] = a ^ b;
                end
            endcase
            prev = b;
        end
    end

    assign enc_ext = WIDE'(enc_chips);
    assign dec_ext = dec_err ? '0 : WIDE'(dec_data);

    // result assembly
    always_comb
    begin
        if (decode_dir_reg)
        begin
            out_res_next.word       = dec_ext[WORD_W-1:0];
            out_res_next.code_error = dec_err;
            last_level_next         = w_ext[CHIPS-1];
        end
        else
        begin
            out_res_next.word       = enc_ext[WORD_W-1:0];
            out_res_next.code_error = 1'b0;
            last_level_next         = enc_chips[CHIPS-1];
        end
        out_res_next.line_level = last_level_next;
    end

    // pipeline control and stored level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_level_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
            begin
                out_valid_reg  <= 1'b1;
                last_level_reg <= last_level_next;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            s1_item_reg <= '{word: word_in, restart: restart};
        if (s1_adv)
            out_res_reg <= out_res_next;
    end

    assign out_valid  = out_valid_reg;
    assign word_out   = out_res_reg.word;
    assign code_error = out_res_reg.code_error;
    assign line_level = out_res_reg.line_level;

endmodule

`default_nettype wire

// ===== rtl/core/blc_checker.sv =====
// port-level checker for the biphase line codec, bound to the top level
// depends on blc_pkg and biphase_line_codec_unit_macros.svh
`default_nettype none

`include "biphase_line_codec_unit_macros.svh"

module blc_checker
    import blc_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [WORD_W-1:0] word_out,
    input wire logic              code_error,
    input wire logic              line_level
);

    // a stalled result holds
    `BLC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(word_out) && $stable(code_error) && $stable(line_level), "stalled result changed")

    // a flagged cell gives zero data
    `BLC_ASSERT_NOW(a_err_zero, out_valid && code_error, word_out == '0, "error result carries data")

    // input is held off only by a stalled full result register
    `BLC_ASSERT_NOW(a_ready_cause, !in_ready, out_valid && !out_ready, "input stalled without output stall")

    // a fresh result follows an input transfer through the input and result registers
    `BLC_ASSERT_NOW(a_latency, $rose(out_valid), $past(in_valid && in_ready, 2), "result without input transfer")

endmodule

bind biphase_line_codec_unit blc_checker u_blc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .word_out   (word_out),
    .code_error (code_error),
    .line_level (line_level)
);

`default_nettype wire
